// File: design/slot_list_line_parser_defines.svh
// Assertion macros used by the slot list line parser checker.
`ifndef SLOT_LIST_LINE_PARSER_DEFINES_SVH
`define SLOT_LIST_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define SLP_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("slot list line parser check failed");

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define SLP_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("slot list line parser check failed");

`endif

// File: design/slp_pkg.sv
// Types, codes and helper functions for the slot list line parser.
package slp_pkg;

	localparam int unsigned NumW = 31;
	localparam logic [NumW-1:0] NUM_MAX = 31'h7FFF_FFFF;

	localparam logic [3:0] PH_NAME_START = 4'd0;
	localparam logic [3:0] PH_NAME       = 4'd1;
	localparam logic [3:0] PH_SEMI       = 4'd2;
	localparam logic [3:0] PH_LIST_OPEN  = 4'd3;
	localparam logic [3:0] PH_BETWEEN    = 4'd4;
	localparam logic [3:0] PH_PAIR_OPEN  = 4'd5;
	localparam logic [3:0] PH_N1_PRE     = 4'd6;
	localparam logic [3:0] PH_N1         = 4'd7;
	localparam logic [3:0] PH_COMMA      = 4'd8;
	localparam logic [3:0] PH_N2_PRE     = 4'd9;
	localparam logic [3:0] PH_N2         = 4'd10;
	localparam logic [3:0] PH_CLOSE      = 4'd11;
	localparam logic [3:0] PH_DONE       = 4'd12;
	localparam logic [3:0] PH_FAIL       = 4'd13;

	localparam logic [1:0] KIND_LETTER = 2'd0;
	localparam logic [1:0] KIND_PAIR   = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [34:0] RADIX   = 35'd10;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [7:0]      name_letter;
		logic [NumW-1:0] slot_start;
		logic [NumW-1:0] slot_end;
		logic            last_result;
	} out_word_t;

	typedef struct packed {
		logic [3:0]      phase;
		logic            pair_seen;
		logic [NumW-1:0] first_value;
		logic [NumW-1:0] number_accum;
	} parse_state_t;

	typedef struct packed {
		logic [1:0] count;
		out_word_t  word0;
		out_word_t  word1;
	} push_t;

	function automatic logic [NumW-1:0] accum_digit(logic [NumW-1:0] acc, logic [7:0] c);
		logic [34:0] v;
		v = 35'(acc) * RADIX + 35'(4'(c - CH_ZERO));
		return (v > 35'(NUM_MAX)) ? NUM_MAX : v[NumW-1:0];
	endfunction

endpackage

// File: design/slp_parse.sv
// Next-state and result logic for one character of the slot list line parser.
module slp_parse (
	input  slp_pkg::parse_state_t state,
	input  slp_pkg::in_word_t     word,
	output slp_pkg::parse_state_t state_next,
	output slp_pkg::push_t        push
);
	import slp_pkg::*;

	logic      ws, lower, digit;
	logic      have_item;
	out_word_t item, status;
	logic [7:0] c;

	assign c     = word.char_code;
	assign ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	assign lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);

	always_comb begin
		parse_state_t s;
		s = state;
		have_item = 1'b0;
		item = '0;
		unique case (state.phase) inside
			PH_NAME_START: begin
				if (lower) begin
					have_item = 1'b1;
					item.kind = KIND_LETTER;
					item.name_letter = c;
					s.phase = PH_NAME;
				end else if (!ws) begin
					s.phase = PH_FAIL;
				end
			end
			PH_NAME: begin
				if (lower) begin
					have_item = 1'b1;
					item.kind = KIND_LETTER;
					item.name_letter = c;
				end else if (ws) begin
					s.phase = PH_SEMI;
				end else if (c == CH_SEMI) begin
					s.phase = PH_LIST_OPEN;
				end else begin
					s.phase = PH_FAIL;
				end
			end
			PH_SEMI: begin
				if (c == CH_SEMI) s.phase = PH_LIST_OPEN;
				else if (!ws) s.phase = PH_FAIL;
			end
			PH_LIST_OPEN: begin
				if (c == CH_OPEN) s.phase = PH_BETWEEN;
				else if (!ws) s.phase = PH_FAIL;
			end
			PH_BETWEEN: begin
				if (c == CH_CLOSE) s.phase = PH_DONE;
				else if (c == CH_COMMA) s.phase = PH_PAIR_OPEN;
				else if (c == CH_OPEN && !state.pair_seen) s.phase = PH_N1_PRE;
				else if (!ws) s.phase = PH_FAIL;
			end
			PH_PAIR_OPEN: begin
				if (c == CH_OPEN) s.phase = PH_N1_PRE;
				else if (!ws) s.phase = PH_FAIL;
			end
			PH_N1_PRE, PH_N2_PRE: begin
				if (digit) begin
					s.number_accum = accum_digit('0, c);
					s.phase = (state.phase == PH_N1_PRE) ? PH_N1 : PH_N2;
				end else if (!ws) begin
					s.phase = PH_FAIL;
				end
			end
			PH_N1: begin
				if (digit) begin
					s.number_accum = accum_digit(state.number_accum, c);
				end else if (ws) begin
					s.first_value = state.number_accum;
					s.phase = PH_COMMA;
				end else if (c == CH_COMMA) begin
					s.first_value = state.number_accum;
					s.phase = PH_N2_PRE;
				end else begin
					s.phase = PH_FAIL;
				end
			end
			PH_COMMA: begin
				if (c == CH_COMMA) s.phase = PH_N2_PRE;
				else if (!ws) s.phase = PH_FAIL;
			end
			PH_N2, PH_CLOSE: begin
				if (digit && state.phase == PH_N2) begin
					s.number_accum = accum_digit(state.number_accum, c);
				end else if (ws && state.phase == PH_N2) begin
					s.phase = PH_CLOSE;
				end else if (c == CH_CLOSE) begin
					have_item = 1'b1;
					item.kind = KIND_PAIR;
					item.slot_start = state.first_value;
					item.slot_end = state.number_accum;
					s.pair_seen = 1'b1;
					s.phase = PH_BETWEEN;
				end else if (!ws) begin
					s.phase = PH_FAIL;
				end
			end
			PH_DONE: begin
				s.phase = PH_DONE;
			end
			default: begin
				s.phase = PH_FAIL;
			end
		endcase

		status = '0;
		status.kind = (s.phase == PH_DONE) ? KIND_ACCEPT : KIND_REJECT;
		status.last_result = 1'b1;

		push = '0;
		if (word.line_end) begin
			state_next = '0;
			state_next.phase = PH_NAME_START;
			if (have_item) begin
				push.count = 2'd2;
				push.word0 = item;
				push.word1 = status;
			end else begin
				push.count = 2'd1;
				push.word0 = status;
			end
		end else begin
			state_next = s;
			if (have_item) begin
				push.count = 2'd1;
				push.word0 = item;
				push.word0.last_result = 1'b1;
			end
		end
	end

endmodule

// File: design/slp_queue.sv
// Result queue that takes up to two words a cycle and hands out one.
module slp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  slp_pkg::push_t    push,
	output logic              has_room,
	output logic              valid,
	input  logic              ready,
	output slp_pkg::out_word_t word
);
	import slp_pkg::*;

	out_word_t         entry_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [QCntW-1:0]  count_q;
	logic              pop;

	assign pop       = valid && ready;
	assign valid     = (count_q != '0);
	assign word      = entry_q[rd_ptr_q];
	assign has_room  = (count_q <= QCntW'(QDepth - 2));
	assign wr_ptr_p1 = wr_ptr_q + QPtrW'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entry_q[wr_ptr_q] <= push.word0;
		if (push.count == 2'd2) entry_q[wr_ptr_p1] <= push.word1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(push.count);
			if (pop) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			count_q <= count_q + QCntW'(push.count) - QCntW'(pop);
		end
	end

endmodule

// File: design/slot_list_line_parser.sv
// Top level of the slot list line parser: input register, parser state and result queue.
// Parses one character per cycle while the result queue has room, at a sustained rate of one word per clock.
// A character enters an input register, the parser state and its results are
// settled from that register, and the results are written into a four-word
// queue that drives the result port. The result port hands out one word per
// cycle while result_ready is high; a character that yields two results (a
// letter or a closed pair on the line's last character) writes both words into
// the queue together, and they leave the result port one after the other. A
// character waits in the input register while the queue holds more than two
// words. No pass is needed after reset.
module slot_list_line_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  slp_pkg::in_word_t  char_word,
	output logic               result_valid,
	input  logic               result_ready,
	output slp_pkg::out_word_t result_word
);
	import slp_pkg::*;

	logic         valid_s1;
	in_word_t     word_s1;
	parse_state_t state_q, state_next;
	push_t        push_raw, push;
	logic         has_room, advance;

	assign advance    = valid_s1 && has_room;
	assign char_ready = !valid_s1 || has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && char_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) word_s1 <= char_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= parse_state_t'{phase: PH_NAME_START, pair_seen: 1'b0,
				first_value: '0, number_accum: '0};
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	slp_parse u_parse (
		.state      (state_q),
		.word       (word_s1),
		.state_next (state_next),
		.push       (push_raw)
	);

	always_comb begin
		push = push_raw;
		if (!advance) push.count = 2'd0;
	end

	slp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.has_room (has_room),
		.valid    (result_valid),
		.ready    (result_ready),
		.word     (result_word)
	);

endmodule

// File: design/slp_checker.sv
// Port-level checks for the slot list line parser and their binding to it.
`include "slot_list_line_parser_defines.svh"

module slp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input slp_pkg::out_word_t result_word
);
	import slp_pkg::*;

	`SLP_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_word))
	`SLP_ASSERT_NOW(a_status_last, result_valid && (result_word.kind == KIND_ACCEPT || result_word.kind == KIND_REJECT), result_word.last_result && result_word.name_letter == 8'd0 && result_word.slot_start == '0 && result_word.slot_end == '0)
	`SLP_ASSERT_NOW(a_letter_lower, result_valid && result_word.kind == KIND_LETTER, result_word.name_letter >= CH_LOW_A && result_word.name_letter <= CH_LOW_Z && result_word.slot_start == '0 && result_word.slot_end == '0)
	`SLP_ASSERT_NOW(a_pair_clean, result_valid && result_word.kind == KIND_PAIR, result_word.name_letter == 8'd0)
	`SLP_ASSERT_NEXT(a_status_follows, result_valid && result_ready && !result_word.last_result, result_valid && (result_word.kind == KIND_ACCEPT || result_word.kind == KIND_REJECT))

endmodule

bind slot_list_line_parser slp_checker u_slp_checker (.*);
